>>> hdl/bcp_pkg.sv
// ----------------------------------------------------------------------------
// bcp_pkg
// Shared types, widths and constants of the braking corridor predictor.
// ----------------------------------------------------------------------------
package bcp_pkg;

  localparam int POINTS_DEF = 50;
  localparam int IDX_W      = 6;
  localparam int POS_W      = 24;
  localparam int LEN_W      = 23;
  localparam int CFG_W      = 13;
  localparam int ANG_W      = 16;
  localparam int CORD_W     = 48;   // CORDIC vector width
  localparam int CZ_W       = 25;   // CORDIC angle, 2^-24 turn
  localparam int TRIG_W     = 17;   // Q15 sin/cos, signed
  localparam int CORD_ITERS = 16;
  localparam int DIV_NUM_W  = 63;
  localparam int DIV_DEN_W  = 21;

  localparam logic [CORD_W-1:0] CORDIC_GAIN = CORD_W'(652032874);
  localparam logic [22:0]       INV_PI_Q24  = 23'd5340354;
  localparam logic [LEN_W-1:0]  LEN_MAX     = {LEN_W{1'b1}};

  typedef enum logic [1:0] {
    CFG_FRONT_AXLE = 2'd0,
    CFG_REAR_AXLE  = 2'd1,
    CFG_BUMPER     = 2'd2,
    CFG_WIDTH      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] front_axle;
    logic [CFG_W-1:0] rear_axle;
    logic [CFG_W-1:0] bumper;
    logic [CFG_W-1:0] body_width;
  } cfg_t;

  // one braking run handed from front to back
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             clamped;
    logic [ANG_W-1:0] slip;
    logic [LEN_W-1:0] ds;
    logic [31:0]      hstep;
  } job_t;

  function automatic logic signed [CZ_W-1:0] atan_entry(input logic [3:0] i);
    logic signed [CZ_W-1:0] r;
    unique case (i)
      4'd0:  r = CZ_W'(2097152);
      4'd1:  r = CZ_W'(1238021);
      4'd2:  r = CZ_W'(654136);
      4'd3:  r = CZ_W'(332050);
      4'd4:  r = CZ_W'(166669);
      4'd5:  r = CZ_W'(83416);
      4'd6:  r = CZ_W'(41718);
      4'd7:  r = CZ_W'(20860);
      4'd8:  r = CZ_W'(10430);
      4'd9:  r = CZ_W'(5215);
      4'd10: r = CZ_W'(2608);
      4'd11: r = CZ_W'(1304);
      4'd12: r = CZ_W'(652);
      4'd13: r = CZ_W'(326);
      4'd14: r = CZ_W'(163);
      default: r = CZ_W'(81);
    endcase
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] sat24(input logic signed [33:0] v);
    logic signed [POS_W-1:0] r;
    if (v > 34'sd8388607) r = 24'sh7FFFFF;
    else if (v < -34'sd8388608) r = 24'sh800000;
    else r = v[POS_W-1:0];
    return r;
  endfunction

endpackage

>>> hdl/braking_corridor_predictor_top.sv
// ----------------------------------------------------------------------------
// braking_corridor_predictor_top
// Braking corridor prediction with a kinematic bicycle model.
// ----------------------------------------------------------------------------
// Usage:
//   A word (speed, deceleration, road wheel angle) is taken on the edge where
//   start is high and busy is low. Each word yields POINTS result words,
//   one pose each, shown for a single cycle with valid_o; last_o marks the
//   final pose. The receiver cannot hold results off.
//   Front: one serial division for the distance and one for the heading step
//   (one bit a cycle), a reciprocal multiply for the step length and three
//   CORDIC passes. Zero deceleration skips the distance division, a zero
//   rear axle the CORDIC passes and the heading division. A two-word queue
//   sits between front and back, so the next word is taken while the
//   previous run is still emitting. Back: two CORDICs in parallel plus
//   product and emit steps per pose; the back end sets the sustained rate.
//   Configuration: cfg_we_i, cfg_idx_i, cfg_data_i, written while idle.
//   Reset: asynchronous, active low; registers take their default geometry,
//   queue empties, no results pending.
// ----------------------------------------------------------------------------
module braking_corridor_predictor_top #(
  parameter int POINTS = bcp_pkg::POINTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_idx_i,
  input  logic [bcp_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                             start,
  output logic                             busy,
  input  logic [14:0]                      speed_i,
  input  logic [12:0]                      deceleration_i,
  input  logic signed [13:0]               road_wheel_angle_i,
  output logic                             valid_o,
  output logic [bcp_pkg::IDX_W-1:0]        point_index_o,
  output logic signed [bcp_pkg::POS_W-1:0] center_x_o,
  output logic signed [bcp_pkg::POS_W-1:0] center_y_o,
  output logic [bcp_pkg::ANG_W-1:0]        heading_o,
  output logic signed [bcp_pkg::POS_W-1:0] left_corner_x_o,
  output logic signed [bcp_pkg::POS_W-1:0] left_corner_y_o,
  output logic signed [bcp_pkg::POS_W-1:0] right_corner_x_o,
  output logic signed [bcp_pkg::POS_W-1:0] right_corner_y_o,
  output logic [bcp_pkg::LEN_W-1:0]        path_length_o,
  output logic                             length_clamped_o,
  output logic                             last_o
);

  bcp_pkg::cfg_t cfg_q;
  bcp_pkg::job_t q_in, q_out;
  logic q_push, q_pop, q_full, q_empty;

  // geometry registers; reset values are the default vehicle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.front_axle <= 13'd1481;
      cfg_q.rear_axle  <= 13'd1593;
      cfg_q.bumper     <= 13'd2466;
      cfg_q.body_width <= 13'd2229;
    end else if (cfg_we_i) begin
      unique case (bcp_pkg::cfg_idx_e'(cfg_idx_i))
        bcp_pkg::CFG_FRONT_AXLE: cfg_q.front_axle <= cfg_data_i;
        bcp_pkg::CFG_REAR_AXLE:  cfg_q.rear_axle  <= cfg_data_i;
        bcp_pkg::CFG_BUMPER:     cfg_q.bumper     <= cfg_data_i;
        bcp_pkg::CFG_WIDTH:      cfg_q.body_width <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front: distance, step length, slip angle, heading step
  bcp_front #(.POINTS(POINTS)) u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .start_i(start), .speed_i,
    .decel_i(deceleration_i), .rwa_i(road_wheel_angle_i), .busy_o(busy),
    .q_full_i(q_full), .q_push_o(q_push), .q_data_o(q_in)
  );

  bcp_queue u_queue (
    .clk_i, .rst_ni, .push_i(q_push), .data_i(q_in), .full_o(q_full),
    .pop_i(q_pop), .empty_o(q_empty), .data_o(q_out)
  );

  // back: pose integration and corner emission
  bcp_back #(.POINTS(POINTS)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .q_empty_i(q_empty), .q_data_i(q_out),
    .q_pop_o(q_pop), .valid_o, .point_index_o, .center_x_o, .center_y_o, .heading_o,
    .left_corner_x_o, .left_corner_y_o, .right_corner_x_o, .right_corner_y_o,
    .path_length_o, .length_clamped_o, .last_o
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full)) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && q_empty)) else $error("queue pop while empty");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |-> (point_index_o == bcp_pkg::IDX_W'(POINTS - 1)))
    else $error("last pose at wrong index");

  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("word taken but front not busy");

endmodule

>>> hdl/bcp_cordic.sv
// ----------------------------------------------------------------------------
// bcp_cordic
// Iterative CORDIC, one micro-rotation per cycle: sin/cos or atan2.
// ----------------------------------------------------------------------------
module bcp_cordic (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic                             vector_i,
  input  logic [bcp_pkg::ANG_W-1:0]        ang_i,
  input  logic signed [31:0]               xv_i,
  input  logic signed [31:0]               yv_i,
  output logic                             done_o,
  output logic signed [bcp_pkg::TRIG_W-1:0] cos_o,
  output logic signed [bcp_pkg::TRIG_W-1:0] sin_o,
  output logic [bcp_pkg::ANG_W-1:0]        atan_o
);

  localparam int W  = bcp_pkg::CORD_W;
  localparam int ZW = bcp_pkg::CZ_W;

  logic signed [W-1:0]  x_q, y_q, xs, ys, x_d, y_d, xr, yr;
  logic signed [ZW-1:0] z_q, z_d, z0, zr;
  logic [3:0]           cnt_q;
  logic                 run_q, fin_q, vec_q, flip_q, done_q, ccw;
  logic [bcp_pkg::ANG_W-1:0] ang_sum, ang_r;
  logic                 flip;
  logic signed [bcp_pkg::TRIG_W-1:0] cos_q, sin_q, c_n, s_n;
  logic [bcp_pkg::ANG_W-1:0] atan_q;

  always_comb begin
    ang_sum = ang_i + 16'h4000;
    flip    = ang_sum[bcp_pkg::ANG_W-1];
    ang_r   = flip ? ang_i + 16'h8000 : ang_i;
    z0      = ZW'($signed({ang_r, 8'h00}));
    xs      = x_q >>> cnt_q;
    ys      = y_q >>> cnt_q;
    ccw     = vec_q ? y_q[W-1] : ~z_q[ZW-1];
    if (ccw) begin
      x_d = x_q - ys;
      y_d = y_q + xs;
      z_d = z_q - bcp_pkg::atan_entry(cnt_q);
    end else begin
      x_d = x_q + ys;
      y_d = y_q - xs;
      z_d = z_q + bcp_pkg::atan_entry(cnt_q);
    end
    xr  = (x_q + W'(16384)) >>> 15;
    yr  = (y_q + W'(16384)) >>> 15;
    zr  = (z_q + ZW'(128)) >>> 8;
    c_n = flip_q ? -xr[bcp_pkg::TRIG_W-1:0] : xr[bcp_pkg::TRIG_W-1:0];
    s_n = flip_q ? -yr[bcp_pkg::TRIG_W-1:0] : yr[bcp_pkg::TRIG_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      vec_q  <= 1'b0;
      flip_q <= 1'b0;
      cnt_q  <= '0;
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
      cos_q  <= '0;
      sin_q  <= '0;
      atan_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
        vec_q <= vector_i;
        if (vector_i) begin
          flip_q <= 1'b0;
          x_q    <= W'(xv_i) << 16;
          y_q    <= W'(yv_i) << 16;
          z_q    <= '0;
        end else begin
          flip_q <= flip;
          x_q    <= bcp_pkg::CORDIC_GAIN;
          y_q    <= '0;
          z_q    <= z0;
        end
      end else if (run_q) begin
        x_q   <= x_d;
        y_q   <= y_d;
        z_q   <= z_d;
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'(bcp_pkg::CORD_ITERS - 1)) begin
          run_q <= 1'b0;
          fin_q <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
        cos_q  <= c_n;
        sin_q  <= s_n;
        atan_q <= zr[bcp_pkg::ANG_W-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign cos_o  = cos_q;
  assign sin_o  = sin_q;
  assign atan_o = atan_q;

endmodule

>>> hdl/bcp_div.sv
// ----------------------------------------------------------------------------
// bcp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bcp_div #(
  parameter int NUM_W = bcp_pkg::DIV_NUM_W,
  parameter int DEN_W = bcp_pkg::DIV_DEN_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CW = $clog2(NUM_W);

  logic [DEN_W-1:0] rem_q, den_q;
  logic [NUM_W-1:0] quo_q;
  logic [CW-1:0]    cnt_q;
  logic             run_q, done_q, ge;
  logic [DEN_W:0]   t, t_sub;

  always_comb begin
    t     = {rem_q, quo_q[NUM_W-1]};
    ge    = t >= {1'b0, den_q};
    t_sub = t - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
        rem_q <= '0;
        den_q <= den_i;
        quo_q <= num_i;
      end else if (run_q) begin
        rem_q <= ge ? t_sub[DEN_W-1:0] : t[DEN_W-1:0];
        quo_q <= {quo_q[NUM_W-2:0], ge};
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(NUM_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

>>> hdl/bcp_front.sv
// ----------------------------------------------------------------------------
// bcp_front
// Takes a word, works out braking distance, step, slip and heading step.
// ----------------------------------------------------------------------------
module bcp_front #(
  parameter int POINTS = bcp_pkg::POINTS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bcp_pkg::cfg_t          cfg_i,
  input  logic                   start_i,
  input  logic [14:0]            speed_i,
  input  logic [12:0]            decel_i,
  input  logic signed [13:0]     rwa_i,
  output logic                   busy_o,
  input  logic                   q_full_i,
  output logic                   q_push_o,
  output bcp_pkg::job_t          q_data_o
);

  typedef enum logic [3:0] {
    F_IDLE, F_LEN, F_DS, F_DSQ, F_ROT_D, F_MUL_D, F_VEC, F_ROT_B, F_M2, F_M3, F_HS,
    F_PUSH
  } fstate_e;

  localparam int NW = bcp_pkg::DIV_NUM_W;
  localparam int DW = bcp_pkg::DIV_DEN_W;
  localparam int TW = bcp_pkg::TRIG_W;

  // step length by reciprocal multiply: exact floor for any 23-bit length
  localparam int DS_DIV = POINTS - 1;
  localparam int DS_SH  = bcp_pkg::LEN_W + $clog2(DS_DIV);
  localparam int RCP_W  = bcp_pkg::LEN_W + 2;
  localparam int PRD_W  = bcp_pkg::LEN_W + RCP_W;
  localparam logic [RCP_W-1:0] DS_RECIP =
    RCP_W'(((64'd1 << DS_SH) + 64'(DS_DIV) - 64'd1) / 64'(DS_DIV));

  fstate_e state_q;
  bcp_pkg::job_t job_q;
  logic [15:0]   delta_q;
  logic          div_go_q, cor_go_q, cor_vec_q, div_done, cor_done, sb_neg_q, push_q;
  logic [NW-1:0] div_num_q, div_quo;
  logic [DW-1:0] div_den_q;
  logic [15:0]   cor_ang_q, cor_atan;
  logic signed [31:0] xv_q, yv_q;
  logic signed [TW-1:0] cor_cos, cor_sin;
  logic [39:0]   m_q;
  logic [42:0]   phi_q, plo_q;
  logic [PRD_W-1:0] ds_prod_q;
  logic [30:0]   v2;
  logic [bcp_pkg::LEN_W-1:0] len_n, ds_n;
  logic          clamp_n;
  logic [13:0]   lfr;
  logic [TW-1:0] sb_abs;
  logic [31:0]   hs_n;

  bcp_div #(.NUM_W(NW), .DEN_W(DW)) u_div (
    .clk_i, .rst_ni, .start_i(div_go_q), .num_i(div_num_q), .den_i(div_den_q),
    .done_o(div_done), .quo_o(div_quo)
  );

  bcp_cordic u_cordic (
    .clk_i, .rst_ni, .start_i(cor_go_q), .vector_i(cor_vec_q), .ang_i(cor_ang_q),
    .xv_i(xv_q), .yv_i(yv_q), .done_o(cor_done), .cos_o(cor_cos), .sin_o(cor_sin),
    .atan_o(cor_atan)
  );

  always_comb begin
    v2      = 31'({speed_i, 1'b0}) * 31'(speed_i);
    clamp_n = div_quo > NW'(bcp_pkg::LEN_MAX);
    len_n   = clamp_n ? bcp_pkg::LEN_MAX : div_quo[bcp_pkg::LEN_W-1:0];
    ds_n    = bcp_pkg::LEN_W'(ds_prod_q >> DS_SH);
    lfr     = {1'b0, cfg_i.front_axle} + {1'b0, cfg_i.rear_axle};
    sb_abs  = cor_sin[TW-1] ? TW'(-cor_sin) : TW'(cor_sin);
    hs_n    = sb_neg_q ? 32'(-div_quo[31:0]) : div_quo[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= F_IDLE;
      div_go_q  <= 1'b0;
      cor_go_q  <= 1'b0;
      cor_vec_q <= 1'b0;
      push_q    <= 1'b0;
      job_q     <= '0;
      delta_q   <= '0;
      div_num_q <= '0;
      div_den_q <= '0;
      cor_ang_q <= '0;
      xv_q      <= '0;
      yv_q      <= '0;
      m_q       <= '0;
      phi_q     <= '0;
      plo_q     <= '0;
      ds_prod_q <= '0;
      sb_neg_q  <= 1'b0;
    end else begin
      div_go_q <= 1'b0;
      cor_go_q <= 1'b0;
      push_q   <= 1'b0;
      unique case (state_q)
        F_IDLE: begin
          if (start_i && !push_q) begin
            delta_q <= 16'($signed(rwa_i));
            if (decel_i == '0) begin
              job_q.len     <= bcp_pkg::LEN_MAX;
              job_q.clamped <= 1'b1;
              state_q       <= F_DS;
            end else begin
              job_q.clamped <= 1'b0;
              div_num_q     <= NW'(v2);
              div_den_q     <= DW'(decel_i);
              div_go_q      <= 1'b1;
              state_q       <= F_LEN;
            end
          end
        end
        F_LEN: begin
          if (div_done) begin
            job_q.len     <= len_n;
            job_q.clamped <= clamp_n;
            state_q       <= F_DS;
          end
        end
        F_DS: begin
          ds_prod_q <= PRD_W'(job_q.len) * PRD_W'(DS_RECIP);
          state_q   <= F_DSQ;
        end
        F_DSQ: begin
          job_q.ds <= ds_n;
          if (cfg_i.rear_axle == '0) begin
            // no rear lever arm: straight run, no slip
            job_q.slip  <= '0;
            job_q.hstep <= '0;
            state_q     <= F_PUSH;
          end else begin
            cor_vec_q <= 1'b0;
            cor_ang_q <= delta_q;
            cor_go_q  <= 1'b1;
            state_q   <= F_ROT_D;
          end
        end
        F_ROT_D: begin
          if (cor_done) begin
            xv_q    <= 32'($signed({1'b0, lfr})) * 32'(cor_cos);
            yv_q    <= 32'($signed({1'b0, cfg_i.rear_axle})) * 32'(cor_sin);
            state_q <= F_MUL_D;
          end
        end
        F_MUL_D: begin
          cor_vec_q <= 1'b1;
          cor_go_q  <= 1'b1;
          state_q   <= F_VEC;
        end
        F_VEC: begin
          if (cor_done) begin
            job_q.slip <= cor_atan;
            cor_vec_q  <= 1'b0;
            cor_ang_q  <= cor_atan;
            cor_go_q   <= 1'b1;
            state_q    <= F_ROT_B;
          end
        end
        F_ROT_B: begin
          if (cor_done) begin
            sb_neg_q <= cor_sin[TW-1];
            m_q      <= 40'(job_q.ds) * 40'(sb_abs);
            state_q  <= F_M2;
          end
        end
        F_M2: begin
          phi_q   <= 43'(m_q[39:20]) * 43'(bcp_pkg::INV_PI_Q24);
          plo_q   <= 43'(m_q[19:0]) * 43'(bcp_pkg::INV_PI_Q24);
          state_q <= F_M3;
        end
        F_M3: begin
          div_num_q <= {phi_q, 20'h00000} + NW'(plo_q);
          div_den_q <= {cfg_i.rear_axle, 8'h00};
          div_go_q  <= 1'b1;
          state_q   <= F_HS;
        end
        F_HS: begin
          if (div_done) begin
            job_q.hstep <= hs_n;
            state_q     <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full_i) begin
            push_q  <= 1'b1;
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  // push is registered, so the queue's full flag lags the push decision; hold off
  // a new run until the push has landed (busy covers it)
  assign busy_o   = (state_q != F_IDLE) || push_q;
  assign q_push_o = push_q;
  assign q_data_o = job_q;

endmodule

>>> hdl/bcp_queue.sv
// ----------------------------------------------------------------------------
// bcp_queue
// Two-entry queue of runs between front and back.
// ----------------------------------------------------------------------------
module bcp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bcp_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output bcp_pkg::job_t data_o
);

  bcp_pkg::job_t mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        mem_q[wptr_q] <= data_i;
        wptr_q        <= ~wptr_q;
      end
      if (pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rptr_q];

endmodule

>>> hdl/bcp_back.sv
// ----------------------------------------------------------------------------
// bcp_back
// Dead-reckons the poses of one run and emits centre and bumper corners.
// ----------------------------------------------------------------------------
module bcp_back #(
  parameter int POINTS = bcp_pkg::POINTS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  bcp_pkg::cfg_t                      cfg_i,
  input  logic                               q_empty_i,
  input  bcp_pkg::job_t                      q_data_i,
  output logic                               q_pop_o,
  output logic                               valid_o,
  output logic [bcp_pkg::IDX_W-1:0]          point_index_o,
  output logic signed [bcp_pkg::POS_W-1:0]   center_x_o,
  output logic signed [bcp_pkg::POS_W-1:0]   center_y_o,
  output logic [bcp_pkg::ANG_W-1:0]          heading_o,
  output logic signed [bcp_pkg::POS_W-1:0]   left_corner_x_o,
  output logic signed [bcp_pkg::POS_W-1:0]   left_corner_y_o,
  output logic signed [bcp_pkg::POS_W-1:0]   right_corner_x_o,
  output logic signed [bcp_pkg::POS_W-1:0]   right_corner_y_o,
  output logic [bcp_pkg::LEN_W-1:0]          path_length_o,
  output logic                               length_clamped_o,
  output logic                               last_o
);

  typedef enum logic [1:0] {B_IDLE, B_GO, B_ROT, B_EMIT} bstate_e;

  localparam int TW = bcp_pkg::TRIG_W;
  localparam int IW = bcp_pkg::IDX_W;

  bstate_e       state_q;
  bcp_pkg::job_t job_q;
  logic [IW-1:0] idx_q;
  logic [31:0]   hacc_q;
  logic signed [31:0] px_q, py_q;
  logic [15:0]   ang_h, ang_m;
  logic          done_h, done_m, pop, is_last;
  logic signed [TW-1:0] ch, sh, cm, sm;
  logic [15:0]   atan_h, atan_m;
  logic signed [30:0] pbc_q, pbs_q, pwc_q, pws_q;
  logic signed [40:0] pdc_q, pds_q;
  logic signed [32:0] olx, oly, orx, ory;
  logic signed [40:0] dx, dy;
  logic signed [14:0] b2;

  assign ang_h   = hacc_q[31:16];
  assign ang_m   = ang_h + job_q.slip;
  assign pop     = (state_q == B_IDLE) && !q_empty_i;
  assign is_last = idx_q == IW'(POINTS - 1);
  assign b2      = $signed({1'b0, cfg_i.bumper, 1'b0});

  bcp_cordic u_cor_h (
    .clk_i, .rst_ni, .start_i(state_q == B_GO), .vector_i(1'b0), .ang_i(ang_h),
    .xv_i(32'sd0), .yv_i(32'sd0), .done_o(done_h), .cos_o(ch), .sin_o(sh), .atan_o(atan_h)
  );

  bcp_cordic u_cor_m (
    .clk_i, .rst_ni, .start_i(state_q == B_GO), .vector_i(1'b0), .ang_i(ang_m),
    .xv_i(32'sd0), .yv_i(32'sd0), .done_o(done_m), .cos_o(cm), .sin_o(sm), .atan_o(atan_m)
  );

  always_comb begin
    olx = (33'(pbc_q) - 33'(pws_q) + 33'sd32768) >>> 16;
    oly = (33'(pbs_q) + 33'(pwc_q) + 33'sd32768) >>> 16;
    orx = (33'(pbc_q) + 33'(pws_q) + 33'sd32768) >>> 16;
    ory = (33'(pbs_q) - 33'(pwc_q) + 33'sd32768) >>> 16;
    dx  = (pdc_q + 41'sd16384) >>> 15;
    dy  = (pds_q + 41'sd16384) >>> 15;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= B_IDLE;
      job_q            <= '0;
      idx_q            <= '0;
      hacc_q           <= '0;
      px_q             <= '0;
      py_q             <= '0;
      pbc_q            <= '0;
      pbs_q            <= '0;
      pwc_q            <= '0;
      pws_q            <= '0;
      pdc_q            <= '0;
      pds_q            <= '0;
      valid_o          <= 1'b0;
      point_index_o    <= '0;
      center_x_o       <= '0;
      center_y_o       <= '0;
      heading_o        <= '0;
      left_corner_x_o  <= '0;
      left_corner_y_o  <= '0;
      right_corner_x_o <= '0;
      right_corner_y_o <= '0;
      path_length_o    <= '0;
      length_clamped_o <= 1'b0;
      last_o           <= 1'b0;
    end else begin
      valid_o <= 1'b0;
      unique case (state_q)
        B_IDLE: begin
          if (pop) begin
            job_q   <= q_data_i;
            idx_q   <= '0;
            hacc_q  <= '0;
            px_q    <= '0;
            py_q    <= '0;
            state_q <= B_GO;
          end
        end
        B_GO: state_q <= B_ROT;
        B_ROT: begin
          if (done_h && done_m) begin
            pbc_q   <= 31'(b2) * 31'(ch);
            pbs_q   <= 31'(b2) * 31'(sh);
            pwc_q   <= 31'($signed({1'b0, cfg_i.body_width})) * 31'(ch);
            pws_q   <= 31'($signed({1'b0, cfg_i.body_width})) * 31'(sh);
            pdc_q   <= 41'($signed({1'b0, job_q.ds})) * 41'(cm);
            pds_q   <= 41'($signed({1'b0, job_q.ds})) * 41'(sm);
            state_q <= B_EMIT;
          end
        end
        B_EMIT: begin
          valid_o          <= 1'b1;
          point_index_o    <= idx_q;
          center_x_o       <= bcp_pkg::sat24(34'(px_q));
          center_y_o       <= bcp_pkg::sat24(34'(py_q));
          heading_o        <= ang_h;
          left_corner_x_o  <= bcp_pkg::sat24(34'(px_q) + 34'(olx));
          left_corner_y_o  <= bcp_pkg::sat24(34'(py_q) + 34'(oly));
          right_corner_x_o <= bcp_pkg::sat24(34'(px_q) + 34'(orx));
          right_corner_y_o <= bcp_pkg::sat24(34'(py_q) + 34'(ory));
          path_length_o    <= job_q.len;
          length_clamped_o <= job_q.clamped;
          last_o           <= is_last;
          px_q             <= px_q + dx[31:0];
          py_q             <= py_q + dy[31:0];
          hacc_q           <= hacc_q + job_q.hstep;
          idx_q            <= idx_q + IW'(1);
          state_q          <= is_last ? B_IDLE : B_GO;
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign q_pop_o = pop;

endmodule

>>> sim/tb_braking_corridor_predictor_top.sv
// ----------------------------------------------------------------------------
// tb_braking_corridor_predictor_top
// Self-checking bench for the braking corridor predictor.
// ----------------------------------------------------------------------------
// Each accepted word is run through a local bit-true model of the path
// prediction: braking distance, CORDIC slip angle, dead-reckoned poses and
// bumper corners. The POINTS poses it yields are queued and checked in order,
// field by field, against every valid_o strobe. A directed part covers the
// field extremes and the special cases, then random words run in phases with
// different sender idling and geometry settings.
// ----------------------------------------------------------------------------
module tb_braking_corridor_predictor_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPOSE       = bcp_pkg::POINTS_DEF;
  localparam int SETTLE_CYC  = 400;     // front latency plus margin
  localparam int PHASE_ITEMS = 70;

  typedef struct {
    logic [5:0]         idx;
    logic signed [23:0] cx, cy;
    logic [15:0]        hdg;
    logic signed [23:0] lx, ly, rx, ry;
    logic [22:0]        len;
    logic               clamped;
    logic               last;
  } pose_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [1:0]        cfg_idx_i = '0;
  logic [bcp_pkg::CFG_W-1:0] cfg_data_i = '0;
  logic              start = 1'b0;
  logic              busy;
  logic [14:0]       speed_i = '0;
  logic [12:0]       deceleration_i = '0;
  logic signed [13:0] road_wheel_angle_i = '0;
  logic              valid_o;
  logic [bcp_pkg::IDX_W-1:0] point_index_o;
  logic signed [bcp_pkg::POS_W-1:0] center_x_o, center_y_o;
  logic [bcp_pkg::ANG_W-1:0] heading_o;
  logic signed [bcp_pkg::POS_W-1:0] left_corner_x_o, left_corner_y_o;
  logic signed [bcp_pkg::POS_W-1:0] right_corner_x_o, right_corner_y_o;
  logic [bcp_pkg::LEN_W-1:0] path_length_o;
  logic              length_clamped_o, last_o;

  // local geometry copy
  logic [12:0] geo_front = 13'd1481;
  logic [12:0] geo_rear  = 13'd1593;
  logic [12:0] geo_bump  = 13'd2466;
  logic [12:0] geo_width = 13'd2229;

  pose_t pose_q[$];
  int    n_err   = 0;
  int    n_words = 0;
  int    n_poses = 0;
  int    idle_pct = 0;

  braking_corridor_predictor_top u_top (.*);

  always #5 clk_i = ~clk_i;

  // --- model ---------------------------------------------------------------
  longint atan_lut[16] = '{2097152, 1238021, 654136, 332050, 166669, 83416,
                           41718, 20860, 10430, 5215, 2608, 1304, 652, 326,
                           163, 81};

  // cos/sin in Q15 of a binary angle; >>> on longint is a floor shift
  task automatic cordic_rot(input logic [15:0] ang, output longint c,
                            output longint s);
    logic [15:0] a;
    bit     flip;
    longint x, y, z, nx, ny;
    a = ang;
    flip = 0;
    if (16'(a + 16'd16384) >= 16'd32768) begin
      a = a + 16'd32768;
      flip = 1;
    end
    x = 652032874;
    y = 0;
    z = longint'($signed(a)) * 256;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_lut[i];
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += atan_lut[i];
      end
      x = nx; y = ny;
    end
    c = (x + 16384) >>> 15;
    s = (y + 16384) >>> 15;
    if (flip) begin
      c = -c; s = -s;
    end
  endtask

  function automatic logic [15:0] cordic_angle(input longint yv, input longint xv);
    longint x, y, z, nx, ny;
    x = xv * 65536; y = yv * 65536; z = 0;
    for (int i = 0; i < 16; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += atan_lut[i];
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_lut[i];
      end
      x = nx; y = ny;
    end
    return 16'((z + 128) >>> 8);
  endfunction

  function automatic logic signed [23:0] clip24(input longint v);
    if (v > 8388607) return 24'sh7FFFFF;
    if (v < -8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  task automatic predict_corridor(input logic [14:0] spd, input logic [12:0] dec,
                                  input logic signed [13:0] rwa);
    longint unsigned len, mag;
    bit          clamped;
    longint      cd, sd, cb, sb, ch, sh, cm, sm, b, w, cx, cy;
    logic [15:0] slip, h;
    logic [31:0] ds, hstep, hacc;
    int          px, py;
    pose_t       p;
    clamped = 0;
    b = geo_bump; w = geo_width;
    if (dec == 0) begin
      len = 8388607; clamped = 1;
    end else begin
      len = (2 * longint'(spd) * longint'(spd)) / longint'(dec);
      if (len > 8388607) begin
        len = 8388607; clamped = 1;
      end
    end
    if (geo_rear == 0) slip = 0;
    else begin
      cordic_rot(16'($signed(rwa)), cd, sd);
      slip = cordic_angle(longint'(geo_rear) * sd,
                          longint'(geo_front + 14'(geo_rear)) * cd);
    end
    cordic_rot(slip, cb, sb);
    ds = 32'(len / (NPOSE - 1));
    if (geo_rear == 0) hstep = 0;
    else begin
      mag = longint'(ds) * (sb < 0 ? -sb : sb);
      mag = mag * 5340354 / (256 * longint'(geo_rear));
      hstep = mag[31:0];
      if (sb < 0) hstep = -hstep;
    end
    px = 0; py = 0; hacc = 0;
    for (int i = 0; i < NPOSE; i++) begin
      h = hacc[31:16];
      cx = px; cy = py;
      cordic_rot(h, ch, sh);
      p.idx = 6'(i);
      p.cx = clip24(cx);
      p.cy = clip24(cy);
      p.hdg = h;
      p.lx = clip24(cx + ((2 * b * ch - w * sh + 32768) >>> 16));
      p.ly = clip24(cy + ((2 * b * sh + w * ch + 32768) >>> 16));
      p.rx = clip24(cx + ((2 * b * ch + w * sh + 32768) >>> 16));
      p.ry = clip24(cy + ((2 * b * sh - w * ch + 32768) >>> 16));
      p.len = len[22:0];
      p.clamped = clamped;
      p.last = (i == NPOSE - 1);
      pose_q.insert(pose_q.size(), p);
      cordic_rot(h + slip, cm, sm);
      px = int'(cx + ((longint'(ds) * cm + 16384) >>> 15));
      py = int'(cy + ((longint'(ds) * sm + 16384) >>> 15));
      hacc = hacc + hstep;
    end
  endtask

  // --- result checking -----------------------------------------------------
  task automatic cmp_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: mismatch %s expected %0d actual %0d", $realtime, name, exp_v, act_v);
      n_err++;
    end
  endtask

  always @(posedge clk_i) begin
    pose_t e;
    if (rst_ni && valid_o) begin
      if (pose_q.size() == 0) begin
        $display("%0t: unexpected pose word, index %0d", $realtime, point_index_o);
        n_err++;
      end else begin
        e = pose_q.pop_front();
        n_poses++;
        cmp_field("point_index", e.idx, point_index_o);
        cmp_field("center_x", e.cx, center_x_o);
        cmp_field("center_y", e.cy, center_y_o);
        cmp_field("heading", e.hdg, heading_o);
        cmp_field("left_corner_x", e.lx, left_corner_x_o);
        cmp_field("left_corner_y", e.ly, left_corner_y_o);
        cmp_field("right_corner_x", e.rx, right_corner_x_o);
        cmp_field("right_corner_y", e.ry, right_corner_y_o);
        cmp_field("path_length", e.len, path_length_o);
        cmp_field("length_clamped", e.clamped, length_clamped_o);
        cmp_field("last", e.last, last_o);
      end
    end
  end

  // --- stimulus helpers ----------------------------------------------------
  task automatic send_word(input logic [14:0] spd, input logic [12:0] dec,
                           input logic signed [13:0] rwa);
    while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    start = 1'b1;
    speed_i = spd; deceleration_i = dec; road_wheel_angle_i = rwa;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    predict_corridor(spd, dec, rwa);
    n_words++;
    @(negedge clk_i);
    start = 1'b0;
    speed_i = 15'($urandom); deceleration_i = 13'($urandom);
    road_wheel_angle_i = 14'($urandom);
  endtask

  // all poses in, then let the front settle before touching anything
  task automatic wait_drained();
    while (pose_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_geometry(input logic [12:0] f, input logic [12:0] r,
                                input logic [12:0] bo, input logic [12:0] wd);
    logic [12:0]       vals[4];
    bcp_pkg::cfg_idx_e ids[4];
    vals = '{f, r, bo, wd};
    ids = '{bcp_pkg::CFG_FRONT_AXLE, bcp_pkg::CFG_REAR_AXLE, bcp_pkg::CFG_BUMPER,
            bcp_pkg::CFG_WIDTH};
    wait_drained();
    for (int i = 0; i < 4; i++) begin
      cfg_we_i = 1'b1; cfg_idx_i = ids[i]; cfg_data_i = vals[i];
      @(negedge clk_i);
    end
    cfg_we_i = 1'b0;
    geo_front = f; geo_rear = r; geo_bump = bo; geo_width = wd;
  endtask

  task automatic send_random();
    logic [14:0] spd;
    logic [12:0] dec;
    logic signed [13:0] rwa;
    spd = 15'($urandom_range(25600));
    dec = ($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(5120, 1));
    if ($urandom_range(7) == 0) rwa = 14'($urandom);
    else rwa = 14'($signed($urandom_range(12742)) - 6371);
    send_word(spd, dec, rwa);
  endtask

  // --- tests ---------------------------------------------------------------
  task automatic test_directed();
    idle_pct = 0;
    send_word(15'd0, 13'd256, 14'sd0);          // standstill
    send_word(15'd25600, 13'd5120, 14'sd6371);  // full speed, full lock left
    send_word(15'd25600, 13'd1, -14'sd6371);    // long distance, clamped
    send_word(15'd5000, 13'd0, 14'sd100);       // zero deceleration
    send_word(15'd16384, 13'd4096, 14'sh2000);  // most negative wheel angle
    send_word(15'd32767, 13'd8191, 14'sd8191);  // all ones, max wheel angle
    send_word(15'd16383, 13'd2000, 14'sd1);
    send_word(15'd3000, 13'd700, -14'sd1);
  endtask

  task automatic test_geometry_extremes();
    write_geometry(13'd1, 13'd8191, 13'd8191, 13'd8191);
    send_word(15'd25600, 13'd300, 14'sd6371);
    send_word(15'd20000, 13'd1, -14'sd6371);
    write_geometry(13'd8191, 13'd1, 13'd0, 13'd0);
    send_word(15'd25600, 13'd300, 14'sd6371);
    send_word(15'd12000, 13'd900, -14'sd4000);
    // zero rear axle offset: no slip, straight path
    write_geometry(13'd1481, 13'd0, 13'd2466, 13'd2229);
    send_word(15'd12000, 13'd900, 14'sd6000);
    send_word(15'd25600, 13'd0, 14'sh2000);
    write_geometry(13'd1481, 13'd1593, 13'd2466, 13'd2229);
  endtask

  task automatic test_random_phase(input int pct);
    write_geometry(13'($urandom_range(8191, 1)), 13'($urandom_range(8191, 1)),
                   13'($urandom), 13'($urandom));
    idle_pct = pct;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      send_random();
      if (i == PHASE_ITEMS / 2 && pct == 33) begin
        // hold the sender until the back end runs dry
        while (pose_q.size() != 0) @(negedge clk_i);
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_geometry_extremes();
    test_random_phase(0);
    test_random_phase(88);
    test_random_phase(33);
    test_random_phase(0);
    wait_drained();
    $display("Covered %0d words and %0d poses: field extremes, clamped lengths,",
             n_words, n_poses);
    $display("zero rear axle, geometry extremes and random idling phases.");
    if (n_err == 0 && pose_q.size() == 0) begin
      $display("PASS braking_corridor_predictor_top");
    end else begin
      $display("FAIL braking_corridor_predictor_top");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("FAIL braking_corridor_predictor_top");
    $finish;
  end

endmodule

>>> files.f
hdl/bcp_pkg.sv
hdl/bcp_cordic.sv
hdl/bcp_div.sv
hdl/bcp_front.sv
hdl/bcp_queue.sv
hdl/bcp_back.sv
hdl/braking_corridor_predictor_top.sv
sim/tb_braking_corridor_predictor_top.sv
